FILE: rtl/core/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// pcbp_pkg: shared types and constants of the catalog byte parser
// Event codes, byte codes, queue sizing and the result/entry structs.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  // Result event codes
  localparam logic [1:0] EV_TEXT  = 2'd0;
  localparam logic [1:0] EV_KEY   = 2'd1;
  localparam logic [1:0] EV_VALUE = 2'd2;
  localparam logic [1:0] EV_EOF   = 2'd3;

  // Byte codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_BOM   = 8'hEF;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Keyword lengths including the trailing space
  localparam logic [2:0] KW_ID_LEN  = 3'd6;
  localparam logic [2:0] KW_STR_LEN = 3'd7;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] ev;
    logic       tg;
    logic [7:0] tb;
    logic       pd;
  } result_t;

  // One accepted byte's work: an optional parse result and an optional end mark
  typedef struct packed {
    logic    r0_valid;
    result_t r0;
    logic    eof;
    logic    eof_pd;
  } entry_t;

  // Keyword character at a position: "msgid " or "msgstr "
  function automatic logic [7:0] kw_char(input logic is_value, input logic [2:0] idx);
    logic [7:0] c;
    c = CH_NUL;
    case (idx)
      3'd0: c = CH_M;
      3'd1: c = CH_S;
      3'd2: c = CH_G;
      3'd3: c = is_value ? CH_S : CH_I;
      3'd4: c = is_value ? CH_T : CH_D;
      3'd5: c = is_value ? CH_R : CH_SPACE;
      3'd6: c = is_value ? CH_SPACE : CH_NUL;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/pcbp_front.sv
// ----------------------------------------------------------------------------
// pcbp_front: byte classifier
// Runs the line state machine on each accepted byte and writes one work
// entry per byte that produces any result.
// ----------------------------------------------------------------------------
module pcbp_front
  import pcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_file,
  output logic       wr_en,
  output entry_t     wr_data
);

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_KEYW   = 3'd1,
    PH_SPACE  = 3'd2,
    PH_TEXT   = 3'd3,
    PH_ESC    = 3'd4,
    PH_IGNORE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SEC_NONE  = 2'd0,
    SEC_KEY   = 2'd1,
    SEC_VALUE = 2'd2,
    SEC_BAD   = 2'd3
  } section_t;

  logic [1:0] bom_skip, bom_skip_next;
  logic       at_file_start, at_file_start_next;
  phase_t     line_phase, line_phase_next;
  logic [2:0] keyword_index, keyword_index_next;
  logic       keyword_is_value, keyword_is_value_next;
  section_t   section, section_next;
  logic       key_nonempty, key_nonempty_next;

  logic       do_parse;
  logic       emit;
  logic [7:0] emit_byte;
  logic [2:0] kw_len;
  logic [2:0] kw_idx_inc;
  phase_t     brk_phase;
  result_t    r0;
  logic       r0_valid;
  logic       eof_pd;

  always_comb begin
    bom_skip_next         = bom_skip;
    at_file_start_next    = at_file_start;
    line_phase_next       = line_phase;
    keyword_index_next    = keyword_index;
    keyword_is_value_next = keyword_is_value;
    section_next          = section;
    key_nonempty_next     = key_nonempty;
    do_parse              = 1'b0;
    emit                  = 1'b0;
    emit_byte             = in_byte;
    r0                    = '0;
    r0_valid              = 1'b0;
    kw_len                = keyword_is_value ? KW_STR_LEN : KW_ID_LEN;
    kw_idx_inc            = keyword_index + 3'd1;
    // end the line at a newline, otherwise ignore the rest of it
    brk_phase             = (in_byte == CH_LF) ? PH_START : PH_IGNORE;

    if (at_file_start) begin
      at_file_start_next = 1'b0;
      if (in_byte == CH_BOM) begin
        bom_skip_next = 2'd2;
      end else begin
        do_parse = 1'b1;
      end
    end else if (bom_skip != 2'd0) begin
      bom_skip_next = bom_skip - 2'd1;
    end else begin
      do_parse = 1'b1;
    end

    if (do_parse) begin
      case (line_phase)
        PH_START: begin
          if (in_byte == CH_HASH) begin
            line_phase_next = PH_IGNORE;
          end else if (in_byte == CH_M) begin
            keyword_index_next    = 3'd1;
            keyword_is_value_next = 1'b0;
            line_phase_next       = PH_KEYW;
          end else if (in_byte == CH_QUOTE) begin
            line_phase_next = PH_TEXT;
          end else begin
            line_phase_next = brk_phase;
          end
        end
        PH_KEYW: begin
          if (keyword_index == 3'd3 && (in_byte == CH_I || in_byte == CH_S)) begin
            keyword_is_value_next = (in_byte == CH_S);
            keyword_index_next    = 3'd4;
          end else if (keyword_index >= kw_len || keyword_index == 3'd3 ||
                       in_byte != kw_char(keyword_is_value, keyword_index)) begin
            line_phase_next = brk_phase;
          end else if (kw_idx_inc < kw_len) begin
            keyword_index_next = kw_idx_inc;
          end else begin
            keyword_index_next = 3'd0;
            line_phase_next    = PH_SPACE;
            r0_valid           = 1'b1;
            if (keyword_is_value) begin
              section_next = SEC_VALUE;
              r0.ev        = EV_VALUE;
            end else begin
              r0.ev             = EV_KEY;
              r0.pd             = (section == SEC_VALUE) && key_nonempty;
              section_next      = SEC_KEY;
              key_nonempty_next = 1'b0;
            end
          end
        end
        PH_SPACE: begin
          if (in_byte == CH_QUOTE) begin
            line_phase_next = PH_TEXT;
          end else if (in_byte != CH_SPACE) begin
            line_phase_next = brk_phase;
          end
        end
        PH_TEXT: begin
          if (in_byte == CH_BSL) begin
            line_phase_next = PH_ESC;
          end else if (in_byte == CH_QUOTE || in_byte == CH_LF || in_byte == CH_NUL) begin
            line_phase_next = brk_phase;
          end else begin
            emit = 1'b1;
          end
        end
        PH_ESC: begin
          if (in_byte == CH_LF || in_byte == CH_NUL) begin
            line_phase_next = brk_phase;
          end else begin
            line_phase_next = PH_TEXT;
            if (in_byte == CH_N) begin
              emit      = 1'b1;
              emit_byte = CH_LF;
            end else if (in_byte == CH_T) begin
              emit      = 1'b1;
              emit_byte = CH_TAB;
            end else if (in_byte == CH_R) begin
              emit      = 1'b1;
              emit_byte = CH_CR;
            end else if (in_byte == CH_QUOTE || in_byte == CH_BSL) begin
              emit = 1'b1;
            end
          end
        end
        default: begin
          line_phase_next = brk_phase;
        end
      endcase
    end

    // text goes only into an open key or value
    if (emit) begin
      if (section == SEC_KEY) begin
        key_nonempty_next = 1'b1;
        r0_valid          = 1'b1;
        r0.ev             = EV_TEXT;
        r0.tg             = 1'b0;
        r0.tb             = emit_byte;
      end else if (section == SEC_VALUE) begin
        r0_valid = 1'b1;
        r0.ev    = EV_TEXT;
        r0.tg    = 1'b1;
        r0.tb    = emit_byte;
      end
    end

    eof_pd = (section_next == SEC_VALUE) && key_nonempty_next;

    // end of file: return to the reset state for the next file
    if (end_of_file) begin
      bom_skip_next         = 2'd0;
      at_file_start_next    = 1'b1;
      line_phase_next       = PH_START;
      keyword_index_next    = 3'd0;
      keyword_is_value_next = 1'b0;
      section_next          = SEC_NONE;
      key_nonempty_next     = 1'b0;
    end
  end

  assign wr_en            = accept && (r0_valid || end_of_file);
  assign wr_data.r0_valid = r0_valid;
  assign wr_data.r0       = r0;
  assign wr_data.eof      = end_of_file;
  assign wr_data.eof_pd   = eof_pd;

  always_ff @(posedge clk) begin
    if (rst) begin
      bom_skip         <= 2'd0;
      at_file_start    <= 1'b1;
      line_phase       <= PH_START;
      keyword_index    <= 3'd0;
      keyword_is_value <= 1'b0;
      section          <= SEC_NONE;
      key_nonempty     <= 1'b0;
    end else if (accept) begin
      bom_skip         <= bom_skip_next;
      at_file_start    <= at_file_start_next;
      line_phase       <= line_phase_next;
      keyword_index    <= keyword_index_next;
      keyword_is_value <= keyword_is_value_next;
      section          <= section_next;
      key_nonempty     <= key_nonempty_next;
    end
  end

endmodule

FILE: rtl/core/pcbp_queue.sv
// ----------------------------------------------------------------------------
// pcbp_queue: work entry queue
// Small register FIFO that decouples the classifier from the result side.
// ----------------------------------------------------------------------------
module pcbp_queue
  import pcbp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   q_full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   q_empty
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/pcbp_back.sv
// ----------------------------------------------------------------------------
// pcbp_back: result sequencer
// Splits each work entry into its one or two results and hands them out.
// ----------------------------------------------------------------------------
module pcbp_back
  import pcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       q_empty,
  output logic       rd_en,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] event_res,
  output logic       target,
  output logic [7:0] text_byte,
  output logic       pair_done,
  output logic       last_result
);

  logic sub;
  logic show_r0;
  logic take;

  assign show_r0 = head.r0_valid && !sub;
  assign empty   = q_empty;
  assign take    = pop && !q_empty;
  // retire the entry unless its end mark still follows
  assign rd_en   = take && !(show_r0 && head.eof);

  always_comb begin
    if (show_r0) begin
      event_res   = head.r0.ev;
      target      = head.r0.tg;
      text_byte   = head.r0.tb;
      pair_done   = head.r0.pd;
      last_result = !head.eof;
    end else begin
      event_res   = EV_EOF;
      target      = 1'b0;
      text_byte   = 8'h00;
      pair_done   = head.eof_pd;
      last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (take) begin
      sub <= show_r0 && head.eof;
    end
  end

endmodule

FILE: rtl/core/po_catalog_byte_parser.sv
// ----------------------------------------------------------------------------
// po_catalog_byte_parser: translation catalog byte parser
// Streams a catalog one byte at a time and reports keys, values and text.
// ----------------------------------------------------------------------------
// The parser takes one raw catalog byte per clock (push while full is low)
// and returns results in order through a queue-style port (pop while empty
// is low). Each byte gives zero, one or two results: a decoded text byte
// tagged for the key or the value, a key or value start (with pair_done set
// on a key start when the previous key was non-empty and had a value), and
// an end-of-file event on the byte marked end_of_file. last_result marks the
// final result of each byte. A combinational line state machine classifies
// bytes, taking one per cycle while not full; results leave at one
// per pop, so a byte that carries both a text or start result and the end
// mark needs two pops. A four-entry queue sits between classifier and
// result side, so full rises only when four bytes with pending results are
// waiting. After the end-of-file byte the parser is back in its reset state
// and ready for the next file, including a leading 0xEF mark skip.
// ----------------------------------------------------------------------------
module po_catalog_byte_parser
  import pcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_file,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] event_res,
  output logic       target,
  output logic [7:0] text_byte,
  output logic       pair_done,
  output logic       last_result
);

  logic   accept;
  logic   wr_en;
  entry_t wr_data;
  logic   q_full;
  logic   rd_en;
  entry_t head;
  logic   q_empty;

  // hold input while the queue has no room for a new entry
  assign full   = q_full;
  assign accept = push && !q_full;

  pcbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_file (end_of_file),
    .wr_en       (wr_en),
    .wr_data     (wr_data)
  );

  pcbp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .q_full  (q_full),
    .rd_en   (rd_en),
    .rd_data (head),
    .q_empty (q_empty)
  );

  pcbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .rd_en       (rd_en),
    .pop         (pop),
    .empty       (empty),
    .event_res   (event_res),
    .target      (target),
    .text_byte   (text_byte),
    .pair_done   (pair_done),
    .last_result (last_result)
  );

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for the catalog byte parser
// Feeds catalog files byte by byte through the push/full port and checks every
// popped result against a cycle-free model of the parser's line state machine.
// ----------------------------------------------------------------------------
// Each test builds its byte stream in file_bytes and sends it one request at a
// time. The sender updates the model when a request is taken and queues the
// results it predicts in pending_results. A separate process pops results with
// random stalls and compares each one with the oldest prediction. Files are
// mostly well formed (keyword lines, quoted text with escapes, comments), with
// broken keywords, stray bytes, truncated files and raw noise mixed in.
// ----------------------------------------------------------------------------
module tb;
  import pcbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Line phases of the parser model
  typedef enum logic [2:0] {
    LP_START,
    LP_KEYWORD,
    LP_SPACES,
    LP_TEXT,
    LP_ESCAPE,
    LP_SKIP
  } line_phase_t;

  typedef enum logic [1:0] {
    SEC_NONE,
    SEC_KEY,
    SEC_VALUE
  } section_t;

  typedef struct packed {
    result_t r;
    logic    last;
  } pending_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       end_of_file;
  logic       empty;
  logic       pop;
  logic [1:0] event_res;
  logic       target;
  logic [7:0] text_byte;
  logic       pair_done;
  logic       last_result;

  // Parser model state
  logic [1:0]  bom_left;
  logic        file_start;
  line_phase_t phase;
  logic [2:0]  kw_idx;
  logic        kw_value;
  section_t    sect;
  logic        key_has_text;

  pending_t    pending_results[$];
  logic [7:0]  file_bytes[$];

  int          send_gap_max;
  int          pop_gap_max;
  int          error_count = 0;
  int unsigned cycle_count;

  po_catalog_byte_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .end_of_file (end_of_file),
    .empty       (empty),
    .pop         (pop),
    .event_res   (event_res),
    .target      (target),
    .text_byte   (text_byte),
    .pair_done   (pair_done),
    .last_result (last_result)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void model_reset();
    bom_left     = 2'd0;
    file_start   = 1'b1;
    phase        = LP_START;
    kw_idx       = 3'd0;
    kw_value     = 1'b0;
    sect         = SEC_NONE;
    key_has_text = 1'b0;
  endfunction

  // A newline starts a fresh line; anything else drops the rest of the line.
  function automatic void end_line(input logic [7:0] b);
    phase = (b == CH_LF) ? LP_START : LP_SKIP;
  endfunction

  // Append a decoded byte to the open string; text outside any section is lost.
  function automatic logic emit_decoded(input logic [7:0] c, output result_t r);
    r = '0;
    if (sect == SEC_KEY) begin
      key_has_text = 1'b1;
      r.ev = EV_TEXT;
      r.tb = c;
      return 1'b1;
    end
    if (sect == SEC_VALUE) begin
      r.ev = EV_TEXT;
      r.tg = 1'b1;
      r.tb = c;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic parse_model(input logic [7:0] b, output result_t r);
    string      word;
    logic [2:0] word_len;
    r = '0;
    case (phase)
      LP_START: begin
        if (b == CH_HASH) begin
          phase = LP_SKIP;
        end else if (b == CH_M) begin
          kw_idx   = 3'd1;
          kw_value = 1'b0;
          phase    = LP_KEYWORD;
        end else if (b == CH_QUOTE) begin
          phase = LP_TEXT;
        end else begin
          end_line(b);
        end
        return 1'b0;
      end
      LP_KEYWORD: begin
        // The fourth letter picks "msgid " or "msgstr ".
        if (kw_idx == 3'd3 && (b == CH_I || b == CH_S)) begin
          kw_value = (b == CH_S);
          kw_idx   = 3'd4;
          return 1'b0;
        end
        word     = kw_value ? "msgstr " : "msgid ";
        word_len = kw_value ? KW_STR_LEN : KW_ID_LEN;
        if (kw_idx >= word_len || kw_idx == 3'd3) begin
          end_line(b);
          return 1'b0;
        end
        if (b != word[kw_idx]) begin
          end_line(b);
          return 1'b0;
        end
        kw_idx = kw_idx + 3'd1;
        if (kw_idx < word_len) return 1'b0;
        kw_idx = 3'd0;
        phase  = LP_SPACES;
        if (kw_value) begin
          sect = SEC_VALUE;
          r.ev = EV_VALUE;
        end else begin
          // A new key hands on the previous pair if it had a value and key text.
          r.ev         = EV_KEY;
          r.pd         = (sect == SEC_VALUE) && key_has_text;
          sect         = SEC_KEY;
          key_has_text = 1'b0;
        end
        return 1'b1;
      end
      LP_SPACES: begin
        if (b == CH_SPACE) return 1'b0;
        if (b == CH_QUOTE) phase = LP_TEXT;
        else end_line(b);
        return 1'b0;
      end
      LP_TEXT: begin
        if (b == CH_BSL) begin
          phase = LP_ESCAPE;
          return 1'b0;
        end
        if (b == CH_QUOTE || b == CH_LF || b == CH_NUL) begin
          end_line(b);
          return 1'b0;
        end
        return emit_decoded(b, r);
      end
      LP_ESCAPE: begin
        if (b == CH_LF || b == CH_NUL) begin
          end_line(b);
          return 1'b0;
        end
        phase = LP_TEXT;
        if (b == CH_N) return emit_decoded(CH_LF, r);
        if (b == CH_T) return emit_decoded(CH_TAB, r);
        if (b == CH_R) return emit_decoded(CH_CR, r);
        if (b == CH_QUOTE || b == CH_BSL) return emit_decoded(b, r);
        return 1'b0;
      end
      default: begin
        end_line(b);
        return 1'b0;
      end
    endcase
  endfunction

  // Work out the results of one taken request and queue them in order.
  function automatic void predict_parser_results(input logic [7:0] b, input logic eof_mark);
    result_t  r;
    pending_t entry;
    logic     got;
    got = 1'b0;
    r   = '0;
    if (file_start) begin
      file_start = 1'b0;
      if (b == CH_BOM) bom_left = 2'd2;
      else got = parse_model(b, r);
    end else if (bom_left != 2'd0) begin
      bom_left = bom_left - 2'd1;
    end else begin
      got = parse_model(b, r);
    end
    if (got) begin
      entry.r    = r;
      entry.last = !eof_mark;
      pending_results.push_back(entry);
    end
    if (eof_mark) begin
      entry.r    = '0;
      entry.r.ev = EV_EOF;
      entry.r.pd = (sect == SEC_VALUE) && key_has_text;
      entry.last = 1'b1;
      pending_results.push_back(entry);
      model_reset();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Enter and leave at a falling edge. Hold push high while full; advance once
  // the request is taken. Push stays high so back-to-back requests never
  // lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] b, input logic eof_mark);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      push        <= 1'b0;
      in_byte     <= 8'($urandom_range(0, 255));
      end_of_file <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    in_byte     <= b;
    end_of_file <= eof_mark;
    do @(posedge clk); while (full);
    predict_parser_results(b, eof_mark);
    @(negedge clk);
  endtask

  // Drop push and hold off until every predicted result has been popped.
  task automatic wait_for_drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Send file_bytes as one file: the last byte carries the end mark.
  task automatic send_catalog();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Catalog generator
  // --------------------------------------------------------------------------
  function automatic void add_word(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endfunction

  function automatic void add_junk();
    int n;
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Quoted text body plus a line end: closed, unterminated, escaped newline
  // or cut short by a zero byte.
  function automatic void add_text_tail();
    int n;
    int sel;
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        file_bytes.push_back(CH_BSL);
        sel = $urandom_range(0, 5);
        case (sel)
          0: file_bytes.push_back(CH_N);
          1: file_bytes.push_back(CH_T);
          2: file_bytes.push_back(CH_R);
          3: file_bytes.push_back(CH_QUOTE);
          4: file_bytes.push_back(CH_BSL);
          default: file_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end else if ($urandom_range(0, 9) < 8) begin
        file_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
      end else begin
        file_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      file_bytes.push_back(CH_QUOTE);
      if ($urandom_range(0, 2) == 0) add_junk();
    end else if (sel == 7) begin
      file_bytes.push_back(CH_BSL);
    end else if (sel == 8) begin
      file_bytes.push_back(CH_NUL);
      add_junk();
    end
    file_bytes.push_back(CH_LF);
  endfunction

  function automatic void add_keyword_line(input string kw);
    add_word(kw);
    file_bytes.push_back(CH_SPACE);
    repeat ($urandom_range(0, 2)) file_bytes.push_back(CH_SPACE);
    if ($urandom_range(0, 7) == 0) begin
      add_junk();
      file_bytes.push_back(CH_LF);
    end else begin
      file_bytes.push_back(CH_QUOTE);
      add_text_tail();
    end
  endfunction

  // Keyword prefix that breaks off, or a line of stray bytes.
  function automatic void add_noise_line();
    string kw;
    int    n;
    if ($urandom_range(0, 1) == 0) begin
      kw = ($urandom_range(0, 1) == 0) ? "msgid" : "msgstr";
      n  = $urandom_range(1, kw.len() - 1);
      for (int i = 0; i < n; i++) file_bytes.push_back(kw[i]);
    end
    add_junk();
    file_bytes.push_back(CH_LF);
  endfunction

  function automatic void build_catalog();
    int lines;
    int kind;
    int keep;
    file_bytes.delete();
    if ($urandom_range(0, 3) == 0) begin
      file_bytes.push_back(CH_BOM);
      file_bytes.push_back(8'($urandom_range(0, 255)));
      file_bytes.push_back(8'($urandom_range(0, 255)));
    end
    lines = $urandom_range(1, 6);
    for (int i = 0; i < lines; i++) begin
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
        add_keyword_line("msgid");
      end else if (kind < 12) begin
        add_keyword_line("msgstr");
      end else if (kind < 15) begin
        file_bytes.push_back(CH_QUOTE);
        add_text_tail();
      end else if (kind < 17) begin
        file_bytes.push_back(CH_HASH);
        add_junk();
        file_bytes.push_back(CH_LF);
      end else begin
        add_noise_line();
      end
    end
    // Cut some files short so the end mark lands mid-line or mid-skip.
    if ($urandom_range(0, 3) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) file_bytes.delete(file_bytes.size() - 1);
    end
  endfunction

  task automatic run_catalogs(input int byte_target);
    int sent;
    sent = 0;
    while (sent < byte_target) begin
      build_catalog();
      sent += file_bytes.size();
      send_catalog();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Leading mark with extreme skipped bytes, comment, key with an escape,
  // value, and an end mark on a text byte so one request gives two results.
  task automatic test_mark_skip_and_pair();
    send_gap_max = 7;
    pop_gap_max  = 7;
    file_bytes.delete();
    file_bytes.push_back(CH_BOM);
    file_bytes.push_back(8'hff);
    file_bytes.push_back(CH_NUL);
    add_word("#\n");
    add_word("msgid \"\\n\"\n");
    add_word("msgstr \"b");
    send_catalog();
  endtask

  task automatic test_mixed_catalogs();
    send_gap_max = 7;
    pop_gap_max  = 7;
    run_catalogs(450);
  endtask

  // No idling on either side: one request and one pop per cycle unless held by full or empty.
  task automatic test_back_to_back();
    send_gap_max = 0;
    pop_gap_max  = 0;
    run_catalogs(200);
  endtask

  // Slow popping fills the result queue and holds full high.
  task automatic test_result_backpressure();
    send_gap_max = 0;
    pop_gap_max  = 7;
    run_catalogs(200);
  endtask

  task automatic test_slow_sender();
    send_gap_max = 7;
    pop_gap_max  = 0;
    run_catalogs(150);
  endtask

  // Raw bytes with a sprinkled end mark and, at random, a leading mark on the first byte.
  task automatic test_raw_bytes();
    logic [7:0] b;
    send_gap_max = 3;
    pop_gap_max  = 3;
    for (int i = 0; i < 100; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 0 && $urandom_range(0, 1) == 0) b = CH_BOM;
      send_byte(b, $urandom_range(0, 15) == 0);
    end
    send_byte(CH_LF, 1'b1);
  endtask

  // Stop mid-file, let every result out, then finish the file.
  task automatic test_pause_until_drained();
    int half;
    logic [7:0] rest[$];
    send_gap_max = 2;
    pop_gap_max  = 5;
    file_bytes.delete();
    add_word("msgid \"k\"\nmsgstr \"v\"\n");
    add_keyword_line("msgid");
    add_keyword_line("msgstr");
    half = file_bytes.size() / 2;
    for (int i = 0; i < half; i++) send_byte(file_bytes[i], 1'b0);
    wait_for_drain();
    for (int i = half; i < file_bytes.size(); i++) rest.push_back(file_bytes[i]);
    file_bytes = rest;
    send_catalog();
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Draw a stall per result, hold pop high until one is taken, capture it at
  // the edge and compare at the next falling edge, after the sender has
  // queued its predictions for that edge.
  initial begin : result_checker
    int         gap;
    pending_t   want;
    logic [1:0] got_ev;
    logic       got_tg;
    logic [7:0] got_tb;
    logic       got_pd;
    logic       got_last;
    pop = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, pop_gap_max);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got_ev   = event_res;
      got_tg   = target;
      got_tb   = text_byte;
      got_pd   = pair_done;
      got_last = last_result;
      @(negedge clk);
      if (pending_results.size() == 0) begin
        $error("result with no pending request: event_res %0d, text_byte %0h",
               got_ev, got_tb);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("event_res", 8'(want.r.ev), 8'(got_ev));
        compare_field("target", 8'(want.r.tg), 8'(got_tg));
        compare_field("text_byte", want.r.tb, got_tb);
        compare_field("pair_done", 8'(want.r.pd), 8'(got_pd));
        compare_field("last_result", 8'(want.last), 8'(got_last));
      end
    end
  end

  // Advance a cycle counter and end the run if it runs away.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("po_catalog_byte_parser regression: fail");
    $finish;
  end

  initial begin : stimulus
    rst          = 1'b1;
    push         = 1'b0;
    in_byte      = 8'h00;
    end_of_file  = 1'b0;
    send_gap_max = 0;
    pop_gap_max  = 0;
    model_reset();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_mark_skip_and_pair();
    test_mixed_catalogs();
    test_pause_until_drained();
    test_back_to_back();
    test_result_backpressure();
    test_raw_bytes();
    test_slow_sender();

    // Let the last results out, then watch a while for strays.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("po_catalog_byte_parser regression: pass");
    end else begin
      $display("po_catalog_byte_parser regression: fail");
    end
    $finish;
  end

endmodule
